FILE: hw/rtl/cut_vertex_counter_assert.svh
// Assertion macros for the cut vertex counter; empty when SYNTH is defined.
`ifndef CUT_VERTEX_COUNTER_ASSERT_SVH
`define CUT_VERTEX_COUNTER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define CVC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cvc assertion failed");
// next-cycle implication
`define CVC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cvc assertion failed");
`else
`define CVC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CVC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/cvc_pkg.sv
// Package: constants, codes and shared structs of the cut vertex counter.
`timescale 1ns / 1ps
package cvc_pkg;
	localparam int MAX_VERTICES = 64;
	localparam int ROW_W = MAX_VERTICES;
	localparam int VIDX_W = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int KIND_W = 2;
	localparam int END_W = 7;
	localparam int VC_W = 7;

	localparam logic [VC_W-1:0] VC_RESET = VC_W'(64);

	localparam logic [KIND_W-1:0] KIND_ADD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EVAL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	// sequencer to component counter
	typedef struct packed {
		logic             start;
		logic [ROW_W-1:0] seed_mask;
		logic [ROW_W-1:0] valid_mask;
	} cc_ctrl_t;

	// component counter row read request
	typedef struct packed {
		logic              re;
		logic [VIDX_W-1:0] addr;
	} cc_rd_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [CNT_W-1:0] count;
	} cc_stat_t;
endpackage

FILE: hw/rtl/cvc_in_if.sv
// Input channel: one word per edge, evaluate or clear command.
`timescale 1ns / 1ps
interface cvc_in_if import cvc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [END_W-1:0]  end_a;
	logic [END_W-1:0]  end_b;

	modport source (output valid, kind, end_a, end_b, input ready);
	modport sink (input valid, kind, end_a, end_b, output ready);
endinterface

FILE: hw/rtl/cvc_out_if.sv
// Result channel: one word per evaluate command.
`timescale 1ns / 1ps
interface cvc_out_if import cvc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] cut_vertex_count;

	modport source (output valid, cut_vertex_count, input ready);
	modport sink (input valid, cut_vertex_count, output ready);
endinterface

FILE: hw/rtl/cvc_cfg_if.sv
// Configuration write channel for the vertex count register.
`timescale 1ns / 1ps
interface cvc_cfg_if import cvc_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [VC_W-1:0] vertex_count;

	modport source (output valid, vertex_count, input ready);
	modport sink (input valid, vertex_count, output ready);
endinterface

FILE: hw/rtl/cvc_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module cvc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end
endmodule

FILE: hw/rtl/cvc_comp_count.sv
// Component counter: flood fill over adjacency rows, one row read per cycle while a pending row is under the pointer.
`timescale 1ns / 1ps
module cvc_comp_count import cvc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cc_ctrl_t         ctrl,
	input  logic [ROW_W-1:0] row,
	output cc_rd_t           rd,
	output cc_stat_t         stat
);
	logic              busy_q;
	logic              infl_q;
	logic [ROW_W-1:0]  seen_q;
	logic [ROW_W-1:0]  pend_q;
	logic [VIDX_W-1:0] ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [ROW_W-1:0] ptr_bit;
	logic [ROW_W-1:0] fresh;
	logic             working;
	logic             issue;
	logic             root;
	logic             finished;

	// pend_q: seen but not yet expanded. The pointer sweeps all rows; a pending
	// row under the pointer is read, and its unseen neighbors come back next cycle.
	// With nothing pending, an unseen live vertex under the pointer opens a component.
	always_comb begin
		ptr_bit = ROW_W'(1) << ptr_q;
		fresh = infl_q ? (row & ctrl.valid_mask & ~seen_q) : '0;
		working = (pend_q != '0) || infl_q;
		issue = busy_q && pend_q[ptr_q];
		root = busy_q && !working && ctrl.valid_mask[ptr_q] && !seen_q[ptr_q];
		finished = busy_q && !working && ((seen_q | ~ctrl.valid_mask) == '1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			infl_q <= 1'b0;
		end else begin
			infl_q <= issue;
			if (ctrl.start) begin
				busy_q <= 1'b1;
			end else if (finished) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			seen_q <= ctrl.seed_mask;
			pend_q <= '0;
			ptr_q <= '0;
			cnt_q <= '0;
		end else if (busy_q) begin
			seen_q <= seen_q | fresh | (root ? ptr_bit : '0);
			pend_q <= (pend_q & ~(issue ? ptr_bit : '0)) | fresh | (root ? ptr_bit : '0);
			if (root) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				ptr_q <= ptr_q + VIDX_W'(1);
			end
		end
	end

	assign rd.re = issue;
	assign rd.addr = ptr_q;
	assign stat.busy = busy_q;
	assign stat.done = finished;
	assign stat.count = cnt_q;
endmodule

FILE: hw/rtl/cut_vertex_counter.sv
// Cut vertex counter top level: edge loader, evaluation sequencer, result register.
// Add edge: two row read-modify-writes (ADD_RA/WA, ADD_RB/WB); dropped when an end is out of range.
// Clear empties the graph. Evaluate: a base component-count pass, then, if any vertex is live, one pass
// per live vertex (min(vertex_count, 64) of them) with that vertex removed; rows are read one at a time.
// No new word is accepted while an item is in progress; the result register frees the input side.
// arst_n clears control, the row valid bits (empty graph) and sets vertex_count to 64.
`timescale 1ns / 1ps
`include "cut_vertex_counter_assert.svh"
module cut_vertex_counter import cvc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	cvc_in_if.sink    item,
	cvc_out_if.source result,
	cvc_cfg_if.sink   cfg
);
	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_ADD_RA = 8'b0000_0010,
		ST_ADD_WA = 8'b0000_0100,
		ST_ADD_RB = 8'b0000_1000,
		ST_ADD_WB = 8'b0001_0000,
		ST_BASE   = 8'b0010_0000,
		ST_REMOVE = 8'b0100_0000,
		ST_EMIT   = 8'b1000_0000
	} state_t;

	state_t            state_q;
	state_t            state_d;
	logic [VC_W-1:0]   vcount_q;
	logic [ROW_W-1:0]  row_valid_q;
	logic [VIDX_W-1:0] ia_q;
	logic [VIDX_W-1:0] ib_q;
	logic [CNT_W-1:0]  base_q;
	logic [CNT_W-1:0]  cuts_q;
	logic [VIDX_W-1:0] vidx_q;
	logic              rdv_q;
	logic              out_valid_q;
	logic [CNT_W-1:0]  out_data_q;

	logic [CNT_W-1:0]  n_live;
	logic [ROW_W-1:0]  valid_mask;
	logic              item_acc;
	logic              edge_ok;
	logic              last_v;
	logic              load_out;
	logic              in_eval;
	logic              ram_we;
	logic              ram_re;
	logic [VIDX_W-1:0] ram_addr;
	logic [ROW_W-1:0]  ram_wdata;
	logic [ROW_W-1:0]  ram_rdata;
	logic [ROW_W-1:0]  row_data;
	cc_ctrl_t          cc_ctrl;
	cc_rd_t            cc_rd;
	cc_stat_t          cc_stat;

	assign n_live = (CNT_W'(vcount_q) > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
		: CNT_W'(vcount_q);

	always_comb begin
		for (int i = 0; i < ROW_W; i++) begin
			valid_mask[i] = (CNT_W'(i) < n_live);
		end
	end

	assign item.ready = (state_q == ST_IDLE);
	assign item_acc = item.valid && item.ready;
	assign cfg.ready = 1'b1;
	assign edge_ok = (item.end_a != '0) && (item.end_b != '0)
		&& (item.end_a <= END_W'(n_live)) && (item.end_b <= END_W'(n_live));
	assign last_v = (CNT_W'(vidx_q) == n_live - CNT_W'(1));
	assign load_out = (state_q == ST_EMIT) && (!out_valid_q || result.ready);
	assign in_eval = (state_q == ST_BASE) || (state_q == ST_REMOVE);
	// rows never written since the last clear read as empty
	assign row_data = rdv_q ? ram_rdata : '0;

	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_re = 1'b0;
		ram_addr = cc_rd.addr;
		ram_wdata = row_data | (ROW_W'(1) << ib_q);
		cc_ctrl.start = 1'b0;
		cc_ctrl.seed_mask = '0;
		cc_ctrl.valid_mask = valid_mask;
		case (state_q)
			ST_IDLE: begin
				if (item_acc) begin
					case (item.kind)
						KIND_ADD: begin
							if (edge_ok) begin
								state_d = ST_ADD_RA;
							end
						end
						KIND_EVAL: begin
							cc_ctrl.start = 1'b1;
							state_d = ST_BASE;
						end
						default: ;
					endcase
				end
			end
			ST_ADD_RA: begin
				ram_re = 1'b1;
				ram_addr = ia_q;
				state_d = ST_ADD_WA;
			end
			ST_ADD_WA: begin
				ram_we = 1'b1;
				ram_addr = ia_q;
				state_d = ST_ADD_RB;
			end
			ST_ADD_RB: begin
				ram_re = 1'b1;
				ram_addr = ib_q;
				state_d = ST_ADD_WB;
			end
			ST_ADD_WB: begin
				ram_we = 1'b1;
				ram_addr = ib_q;
				ram_wdata = row_data | (ROW_W'(1) << ia_q);
				state_d = ST_IDLE;
			end
			ST_BASE: begin
				ram_re = cc_rd.re;
				if (cc_stat.done) begin
					if (n_live == '0) begin
						state_d = ST_EMIT;
					end else begin
						cc_ctrl.start = 1'b1;
						cc_ctrl.seed_mask = ROW_W'(1);
						state_d = ST_REMOVE;
					end
				end
			end
			ST_REMOVE: begin
				ram_re = cc_rd.re;
				if (cc_stat.done) begin
					if (last_v) begin
						state_d = ST_EMIT;
					end else begin
						// next pass starts with the next vertex marked removed
						cc_ctrl.start = 1'b1;
						cc_ctrl.seed_mask = ROW_W'(1) << (vidx_q + VIDX_W'(1));
					end
				end
			end
			ST_EMIT: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vcount_q <= VC_RESET;
			row_valid_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				vcount_q <= cfg.vertex_count;
			end
			if (item_acc && item.kind == KIND_CLEAR) begin
				row_valid_q <= '0;
			end else if (ram_we) begin
				row_valid_q[ram_addr] <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			ia_q <= VIDX_W'(item.end_a - END_W'(1));
			ib_q <= VIDX_W'(item.end_b - END_W'(1));
		end
		if (ram_re) begin
			rdv_q <= row_valid_q[ram_addr];
		end
		if (state_q == ST_BASE && cc_stat.done) begin
			base_q <= cc_stat.count;
			cuts_q <= '0;
			vidx_q <= '0;
		end
		if (state_q == ST_REMOVE && cc_stat.done) begin
			if (cc_stat.count > base_q) begin
				cuts_q <= cuts_q + CNT_W'(1);
			end
			if (!last_v) begin
				vidx_q <= vidx_q + VIDX_W'(1);
			end
		end
		if (load_out) begin
			out_data_q <= cuts_q;
		end
	end

	assign result.valid = out_valid_q;
	assign result.cut_vertex_count = out_data_q;

	cvc_ram #(
		.WIDTH(ROW_W),
		.DEPTH(MAX_VERTICES)
	) u_adj_ram (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	cvc_comp_count u_comp_count (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (cc_ctrl),
		.row   (row_data),
		.rd    (cc_rd),
		.stat  (cc_stat)
	);

	`CVC_ASSERT_IMP(a_done_in_eval, clk, arst_n, cc_stat.done, in_eval)
	`CVC_ASSERT_IMP(a_busy_in_eval, clk, arst_n, cc_stat.busy, in_eval)
	`CVC_ASSERT_IMP(a_write_in_add, clk, arst_n, ram_we, state_q == ST_ADD_WA || state_q == ST_ADD_WB)
	`CVC_ASSERT_IMP(a_cuts_bound, clk, arst_n, state_q == ST_REMOVE, cuts_q <= CNT_W'(vidx_q))
	`CVC_ASSERT_NXT(a_emit_loads, clk, arst_n, load_out, out_valid_q && state_q == ST_IDLE)
endmodule
